// File: rtl/core/assert_macros.svh
// Assertion macros used by the port checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Plain property, checked outside reset.
`define QDSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qdss port check failed");
// Trigger in a cycle, consequence in the next.
`define QDSS_ASSERT_NEXT(lbl, trig, prop) \
  `QDSS_ASSERT(lbl, (trig) |=> (prop))
`endif

// File: rtl/core/qdss_pkg.sv
// Shared types and constants for the QUIC DCID socket steering block.
// No dependencies.
package qdss_pkg;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_INS  = 2'd1;
  localparam logic [1:0] KIND_REM  = 2'd2;

  localparam logic [2:0] OUT_BY_DCID  = 3'd0;
  localparam logic [2:0] OUT_BY_LIS   = 3'd1;
  localparam logic [2:0] OUT_BAD      = 3'd2;
  localparam logic [2:0] OUT_NO_LIS   = 3'd3;
  localparam logic [2:0] OUT_UPDATED  = 3'd4;
  localparam logic [2:0] OUT_FULL     = 3'd5;
  localparam logic [2:0] OUT_ABSENT   = 3'd6;

  localparam logic [1:0] REG_WC0 = 2'd0;
  localparam logic [1:0] REG_WC1 = 2'd1;

  localparam logic [15:0] FLAGS_POS     = 16'd8;
  localparam logic [15:0] LEN_POS       = 16'd13;
  localparam logic [4:0]  LONG_CID_POS  = 5'd14;
  localparam logic [4:0]  SHORT_CID_POS = 5'd9;
  localparam logic [15:0] KEY_BYTES     = 16'd8;
  localparam logic [7:0]  LIS_TAG       = 8'hFF;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SRCH   = 6'b000010,
    S_LSTART = 6'b000100,
    S_MOD    = 6'b001000,
    S_LSRCH  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic free_ok;
  } tbl_stat_t;

endpackage

// File: rtl/core/qdss_if.sv
// Request and result channel interfaces for the steering block.
// Depends on nothing; widths follow the field definitions.
interface qdss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] flow_hash;
  logic [63:0] entry_key;
  logic [15:0] entry_socket;
  modport source(output valid, kind, data_byte, last_byte, flow_hash, entry_key,
                 entry_socket, input ready);
  modport sink(input valid, kind, data_byte, last_byte, flow_hash, entry_key,
               entry_socket, output ready);
endinterface

interface qdss_out_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic [2:0]  outcome;
  logic [15:0] chosen_socket;
  logic        chosen_master;
  logic [9:0]  chosen_worker;
  logic [63:0] matched_key;
  modport source(output valid, verdict, outcome, chosen_socket, chosen_master,
                 chosen_worker, matched_key, input ready);
  modport sink(input valid, verdict, outcome, chosen_socket, chosen_master,
               chosen_worker, matched_key, output ready);
endinterface

// File: rtl/core/qdss_table.sv
// Socket table: key and socket memories, per-entry valid flops, linear search.
// Depends on qdss_pkg for the status struct.
module qdss_table #(
  parameter int ENTRIES = 64,
  parameter int IW = $clog2(ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         key,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_slot,
  input  logic [63:0]         wr_key,
  input  logic [15:0]         wr_sock,
  input  logic                clr_en,
  input  logic [IW-1:0]       clr_slot,
  output qdss_pkg::tbl_stat_t stat,
  output logic [IW-1:0]       hit_slot,
  output logic [IW-1:0]       free_slot,
  output logic [15:0]         hit_sock
);

  logic [63:0]        keys_mem [ENTRIES];
  logic [15:0]        sock_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  logic          busy_r;
  logic [IW:0]   rd_idx_r;
  logic          cmp_v_r;
  logic [IW-1:0] cmp_idx_r;
  logic [63:0]   rk_r;
  logic [15:0]   rs_r;
  logic          rv_r;
  logic          done_r, hit_r, free_ok_r;
  logic [IW-1:0] hit_slot_r, free_slot_r;
  logic [15:0]   hit_sock_r;
  logic          rd_go;

  assign rd_go = busy_r && (rd_idx_r < (IW+1)'(ENTRIES));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_mem[wr_slot] <= wr_key;
      sock_mem[wr_slot] <= wr_sock;
    end
    if (rd_go) begin
      rk_r <= keys_mem[rd_idx_r[IW-1:0]];
      rs_r <= sock_mem[rd_idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (wr_en) valid_r[wr_slot] <= 1'b1;
      if (clr_en) valid_r[clr_slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rd_idx_r    <= '0;
      cmp_v_r     <= 1'b0;
      cmp_idx_r   <= '0;
      rv_r        <= 1'b0;
      done_r      <= 1'b0;
      hit_r       <= 1'b0;
      free_ok_r   <= 1'b0;
      hit_slot_r  <= '0;
      free_slot_r <= '0;
      hit_sock_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r    <= 1'b1;
        rd_idx_r  <= '0;
        cmp_v_r   <= 1'b0;
        hit_r     <= 1'b0;
        free_ok_r <= 1'b0;
      end else if (busy_r) begin
        cmp_v_r <= rd_go;
        if (rd_go) begin
          rv_r      <= valid_r[rd_idx_r[IW-1:0]];
          cmp_idx_r <= rd_idx_r[IW-1:0];
          rd_idx_r  <= rd_idx_r + 1'b1;
        end
        if (cmp_v_r) begin
          if (rv_r && rk_r == key) begin
            hit_r      <= 1'b1;
            hit_slot_r <= cmp_idx_r;
            hit_sock_r <= rs_r;
            done_r     <= 1'b1;
            busy_r     <= 1'b0;
          end else begin
            if (!rv_r && !free_ok_r) begin
              free_ok_r   <= 1'b1;
              free_slot_r <= cmp_idx_r;
            end
            if (cmp_idx_r == IW'(ENTRIES-1)) begin
              done_r <= 1'b1;
              busy_r <= 1'b0;
            end
          end
        end
      end
    end
  end

  assign stat.done    = done_r;
  assign stat.hit     = hit_r;
  assign stat.free_ok = free_ok_r;
  assign hit_slot     = hit_slot_r;
  assign free_slot    = free_slot_r;
  assign hit_sock     = hit_sock_r;

endmodule

// File: rtl/core/qdss_mod.sv
// Restoring remainder unit: 32-bit hash modulo a 10-bit worker count.
// One quotient bit per cycle; no package dependencies.
module qdss_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [9:0]  divisor,
  output logic        done,
  output logic [9:0]  rem
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r;
  logic [9:0]  rem_r;
  logic [9:0]  d_r;
  logic [10:0] trial;

  assign trial = {rem_r, q_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      q_r    <= '0;
      rem_r  <= '0;
      d_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        // The partial remainder stays below the divisor, so it fits in 10 bits.
        if (trial >= {1'b0, d_r}) rem_r <= 10'(trial - {1'b0, d_r});
        else rem_r <= trial[9:0];
        q_r   <= {q_r[30:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/core/quic_dcid_socket_steering.sv
// QUIC DCID socket steering top level. A datagram byte without the last flag
// is taken with the block staying idle. Insert and remove run one table scan,
// which reads one entry per cycle. A final byte runs up to three scans plus two
// remainder passes, and then may wait while the result register is full.
// Synchronous active-low reset clears the parser, the valid bits and counts.
module quic_dcid_socket_steering #(
  parameter int TABLE_ENTRIES = 64,
  parameter int CID_BYTES = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  qdss_in_if.sink           in_req,
  qdss_out_if.source        out_res,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_wdata
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  qdss_pkg::state_t state_r;
  logic [9:0]  wc0_r, wc1_r;
  logic [15:0] pos_r;
  logic        long_r, cidok_r;
  logic [63:0] acc_r;
  logic [1:0]  op_r;
  logic [63:0] key_r;
  logic [15:0] sock_r;
  logic [31:0] hash_r;
  logic        master_r, try_r, tried_master_r;
  logic [9:0]  worker_r;
  logic        start_r;
  logic        res_verdict_r, res_master_r;
  logic [2:0]  res_outcome_r;
  logic [15:0] res_sock_r;
  logic [9:0]  res_worker_r;
  logic [63:0] res_key_r;
  logic        ov_r, om_r, overd_r;
  logic [2:0]  oout_r;
  logic [15:0] osock_r;
  logic [9:0]  owork_r;
  logic [63:0] okey_r;

  qdss_pkg::tbl_stat_t tstat;
  logic [IW-1:0] hit_slot, free_slot;
  logic [15:0]   hit_sock;
  logic          wr_en, clr_en, div_start, div_done;
  logic [9:0]    div_rem, cur_count;

  // Byte parser, evaluated for the byte on the channel.
  logic        acc_ok;
  logic        long_n, cidok_n, inkey;
  logic [4:0]  cid_start;
  logic [15:0] pos_n;
  logic [63:0] acc_n;
  logic [16:0] len, need;

  assign acc_ok = in_req.valid && state_r == qdss_pkg::S_IDLE;
  assign long_n = (pos_r == qdss_pkg::FLAGS_POS) ? in_req.data_byte[7] : long_r;
  assign cidok_n = (pos_r == qdss_pkg::LEN_POS && long_n)
                   ? (in_req.data_byte == 8'(CID_BYTES)) : cidok_r;
  assign cid_start = long_n ? qdss_pkg::LONG_CID_POS : qdss_pkg::SHORT_CID_POS;
  assign inkey = pos_r > qdss_pkg::FLAGS_POS && pos_r >= {11'd0, cid_start}
                 && pos_r < {11'd0, cid_start} + qdss_pkg::KEY_BYTES;
  assign acc_n = inkey ? {acc_r[55:0], in_req.data_byte} : acc_r;
  assign pos_n = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;
  assign len   = {1'b0, pos_r} + 17'd1;
  assign need  = {12'd0, cid_start} + 17'(CID_BYTES);

  assign cur_count = master_r ? wc1_r : wc0_r;
  assign div_start = state_r == qdss_pkg::S_LSTART && cur_count != 10'd0;
  assign wr_en  = state_r == qdss_pkg::S_SRCH && tstat.done && op_r == qdss_pkg::KIND_INS
                  && (tstat.hit || tstat.free_ok);
  assign clr_en = state_r == qdss_pkg::S_SRCH && tstat.done && op_r == qdss_pkg::KIND_REM
                  && tstat.hit;

  qdss_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
    .clk(clk), .rst_n(rst_n), .start(start_r), .key(key_r),
    .wr_en(wr_en), .wr_slot(tstat.hit ? hit_slot : free_slot),
    .wr_key(key_r), .wr_sock(sock_r), .clr_en(clr_en), .clr_slot(hit_slot),
    .stat(tstat), .hit_slot(hit_slot), .free_slot(free_slot), .hit_sock(hit_sock)
  );

  qdss_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(hash_r),
    .divisor(cur_count), .done(div_done), .rem(div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc0_r <= '0;
      wc1_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == qdss_pkg::REG_WC0) wc0_r <= cfg_wdata;
      else if (cfg_index == qdss_pkg::REG_WC1) wc1_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= qdss_pkg::S_IDLE;
      pos_r          <= '0;
      long_r         <= 1'b0;
      cidok_r        <= 1'b0;
      acc_r          <= '0;
      op_r           <= qdss_pkg::KIND_BYTE;
      key_r          <= '0;
      sock_r         <= '0;
      hash_r         <= '0;
      master_r       <= 1'b0;
      try_r          <= 1'b0;
      tried_master_r <= 1'b0;
      worker_r       <= '0;
      start_r        <= 1'b0;
      res_verdict_r  <= 1'b0;
      res_outcome_r  <= qdss_pkg::OUT_BAD;
      res_sock_r     <= '0;
      res_master_r   <= 1'b0;
      res_worker_r   <= '0;
      res_key_r      <= '0;
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        qdss_pkg::S_IDLE: begin
          if (acc_ok) begin
            op_r <= in_req.kind;
            if (in_req.kind == qdss_pkg::KIND_INS || in_req.kind == qdss_pkg::KIND_REM) begin
              key_r   <= in_req.entry_key;
              sock_r  <= in_req.entry_socket;
              start_r <= 1'b1;
              state_r <= qdss_pkg::S_SRCH;
            end else if (in_req.kind == qdss_pkg::KIND_BYTE) begin
              if (!in_req.last_byte) begin
                pos_r   <= pos_n;
                long_r  <= long_n;
                cidok_r <= cidok_n;
                acc_r   <= acc_n;
              end else begin
                pos_r          <= '0;
                long_r         <= 1'b0;
                cidok_r        <= 1'b0;
                acc_r          <= '0;
                hash_r         <= in_req.flow_hash;
                master_r       <= in_req.flow_hash[31];
                try_r          <= 1'b0;
                tried_master_r <= 1'b0;
                worker_r       <= '0;
                res_verdict_r  <= 1'b0;
                res_outcome_r  <= qdss_pkg::OUT_BAD;
                res_sock_r     <= '0;
                res_master_r   <= 1'b0;
                res_worker_r   <= '0;
                res_key_r      <= '0;
                priority if (len <= 17'd8 || (long_n && len <= 17'd13)) begin
                  state_r <= qdss_pkg::S_OUT;
                end else if (long_n && !cidok_n) begin
                  key_r   <= '0;
                  state_r <= qdss_pkg::S_LSTART;
                end else if (len < need) begin
                  state_r <= qdss_pkg::S_OUT;
                end else begin
                  key_r   <= acc_n;
                  start_r <= 1'b1;
                  state_r <= qdss_pkg::S_SRCH;
                end
              end
            end
          end
        end
        qdss_pkg::S_SRCH: begin
          if (tstat.done) begin
            res_key_r    <= key_r;
            res_sock_r   <= '0;
            res_master_r <= 1'b0;
            res_worker_r <= '0;
            state_r      <= qdss_pkg::S_OUT;
            if (op_r == qdss_pkg::KIND_INS) begin
              res_verdict_r <= 1'b0;
              res_outcome_r <= (tstat.hit || tstat.free_ok)
                               ? qdss_pkg::OUT_UPDATED : qdss_pkg::OUT_FULL;
            end else if (op_r == qdss_pkg::KIND_REM) begin
              res_verdict_r <= 1'b0;
              res_outcome_r <= tstat.hit ? qdss_pkg::OUT_UPDATED : qdss_pkg::OUT_ABSENT;
            end else if (tstat.hit) begin
              res_verdict_r <= 1'b1;
              res_outcome_r <= qdss_pkg::OUT_BY_DCID;
              res_sock_r    <= hit_sock;
            end else begin
              state_r <= qdss_pkg::S_LSTART;
            end
          end
        end
        qdss_pkg::S_LSTART: begin
          if (cur_count != 10'd0) begin
            state_r <= qdss_pkg::S_MOD;
          end else if (try_r) begin
            res_verdict_r <= 1'b0;
            res_outcome_r <= qdss_pkg::OUT_NO_LIS;
            res_sock_r    <= '0;
            res_master_r  <= tried_master_r;
            res_worker_r  <= worker_r;
            res_key_r     <= key_r;
            state_r       <= qdss_pkg::S_OUT;
          end else begin
            master_r <= ~master_r;
            try_r    <= 1'b1;
          end
        end
        qdss_pkg::S_MOD: begin
          if (div_done) begin
            worker_r       <= div_rem;
            tried_master_r <= master_r;
            key_r          <= {qdss_pkg::LIS_TAG, 7'd0, master_r, 38'd0, div_rem};
            start_r        <= 1'b1;
            state_r        <= qdss_pkg::S_LSRCH;
          end
        end
        qdss_pkg::S_LSRCH: begin
          if (tstat.done) begin
            if (tstat.hit || try_r) begin
              res_verdict_r <= tstat.hit;
              res_outcome_r <= tstat.hit ? qdss_pkg::OUT_BY_LIS : qdss_pkg::OUT_NO_LIS;
              res_sock_r    <= tstat.hit ? hit_sock : 16'd0;
              res_master_r  <= master_r;
              res_worker_r  <= worker_r;
              res_key_r     <= key_r;
              state_r       <= qdss_pkg::S_OUT;
            end else begin
              master_r <= ~master_r;
              try_r    <= 1'b1;
              state_r  <= qdss_pkg::S_LSTART;
            end
          end
        end
        qdss_pkg::S_OUT: begin
          if (!ov_r || out_res.ready) state_r <= qdss_pkg::S_IDLE;
        end
        default: state_r <= qdss_pkg::S_IDLE;
      endcase
    end
  end

  // Result register; the sequencer waits in S_OUT until it is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == qdss_pkg::S_OUT && (!ov_r || out_res.ready)) begin
      ov_r <= 1'b1;
    end else if (out_res.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == qdss_pkg::S_OUT && (!ov_r || out_res.ready)) begin
      overd_r <= res_verdict_r;
      oout_r  <= res_outcome_r;
      osock_r <= res_sock_r;
      om_r    <= res_master_r;
      owork_r <= res_worker_r;
      okey_r  <= res_key_r;
    end
  end

  assign in_req.ready          = state_r == qdss_pkg::S_IDLE;
  assign out_res.valid         = ov_r;
  assign out_res.verdict       = overd_r;
  assign out_res.outcome       = oout_r;
  assign out_res.chosen_socket = osock_r;
  assign out_res.chosen_master = om_r;
  assign out_res.chosen_worker = owork_r;
  assign out_res.matched_key   = okey_r;

endmodule

// File: rtl/core/qdss_checker.sv
// Port-level checker for the steering block, bound to the top level.
// Depends on qdss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qdss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_outcome,
  input logic [15:0] out_socket,
  input logic [63:0] out_key
);

  `QDSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `QDSS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_outcome) && $stable(out_socket) && $stable(out_key))
  `QDSS_ASSERT_NEXT(a_tbl_busy, in_valid && in_ready && (in_kind == qdss_pkg::KIND_INS || in_kind == qdss_pkg::KIND_REM), !in_ready)
  `QDSS_ASSERT_NEXT(a_byte_quick, in_valid && in_ready && in_kind == qdss_pkg::KIND_BYTE && !in_last, in_ready)

endmodule

bind quic_dcid_socket_steering qdss_checker u_qdss_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_req.valid), .in_ready(in_req.ready), .in_kind(in_req.kind),
  .in_last(in_req.last_byte),
  .out_valid(out_res.valid), .out_ready(out_res.ready),
  .out_outcome(out_res.outcome), .out_socket(out_res.chosen_socket),
  .out_key(out_res.matched_key)
);

// File: sim/tb_quic_dcid_socket_steering.sv
// Self-checking testbench for the QUIC DCID socket steering block.
// Needs qdss_pkg and the channel interfaces from the RTL; it drives requests and
// table updates, predicts each verdict, and checks every result field.
module tb_quic_dcid_socket_steering;

  localparam int NSLOTS = 64;
  localparam int CIDLEN = 20;
  localparam int SETTLE = 300;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] flow_hash;
    logic [63:0] entry_key;
    logic [15:0] entry_socket;
  } steer_req_t;

  typedef struct {
    logic        verdict;
    logic [2:0]  outcome;
    logic [15:0] chosen_socket;
    logic        chosen_master;
    logic [9:0]  chosen_worker;
    logic [63:0] matched_key;
  } verdict_t;

  typedef struct {
    steer_req_t req;
    bit         fixed;
    verdict_t   res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_wdata;

  qdss_in_if  in_req();
  qdss_out_if out_res();

  quic_dcid_socket_steering dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the block state.
  logic [63:0] sh_keys [NSLOTS];
  logic [15:0] sh_socks[NSLOTS];
  bit          sh_valid[NSLOTS];
  logic [15:0] sh_pos;
  bit          sh_long;
  bit          sh_len_ok;
  logic [63:0] sh_acc;
  logic [9:0]  sh_wc0, sh_wc1;

  verdict_t    pending_verdicts[$];
  int          errors;
  int          sent;
  bit          quiet;
  bit          no_stall;
  logic [63:0] key_pool[8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  function automatic int slot_of(logic [63:0] k);
    for (int i = 0; i < NSLOTS; i++)
      if (sh_valid[i] && sh_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic verdict_t mk(logic v, logic [2:0] o, logic [15:0] s, logic m,
                                  logic [9:0] w, logic [63:0] k);
    verdict_t r;
    r.verdict = v; r.outcome = o; r.chosen_socket = s;
    r.chosen_master = m; r.chosen_worker = w; r.matched_key = k;
    return r;
  endfunction

  function automatic void clear_parse();
    sh_pos = '0; sh_long = 0; sh_len_ok = 0; sh_acc = '0;
  endfunction

  function automatic logic [63:0] listener_key(logic m, logic [9:0] w);
    return {qdss_pkg::LIS_TAG, 7'd0, m, 38'd0, w};
  endfunction

  // Works out the result of one accepted request and advances the shadow state.
  function automatic bit steer_predict(steer_req_t r, output verdict_t e);
    int s, pos, len, cs;
    bit bad, to_lis, tried;
    logic m, tm;
    logic [9:0] cnt, w;
    logic [63:0] k;
    e = mk(1'b0, qdss_pkg::OUT_BAD, 16'd0, 1'b0, 10'd0, 64'd0);
    if (r.kind == qdss_pkg::KIND_INS) begin
      s = slot_of(r.entry_key);
      if (s < 0)
        for (int i = 0; i < NSLOTS; i++)
          if (!sh_valid[i]) begin s = i; break; end
      if (s < 0) begin
        e = mk(1'b0, qdss_pkg::OUT_FULL, 16'd0, 1'b0, 10'd0, r.entry_key);
        return 1;
      end
      sh_keys[s] = r.entry_key; sh_socks[s] = r.entry_socket; sh_valid[s] = 1;
      e = mk(1'b0, qdss_pkg::OUT_UPDATED, 16'd0, 1'b0, 10'd0, r.entry_key);
      return 1;
    end
    if (r.kind == qdss_pkg::KIND_REM) begin
      s = slot_of(r.entry_key);
      if (s < 0) begin
        e = mk(1'b0, qdss_pkg::OUT_ABSENT, 16'd0, 1'b0, 10'd0, r.entry_key);
        return 1;
      end
      sh_valid[s] = 0;
      e = mk(1'b0, qdss_pkg::OUT_UPDATED, 16'd0, 1'b0, 10'd0, r.entry_key);
      return 1;
    end
    if (r.kind != qdss_pkg::KIND_BYTE) return 0;

    pos = int'(sh_pos);
    if (pos == qdss_pkg::FLAGS_POS) sh_long = r.data_byte[7];
    if (pos == qdss_pkg::LEN_POS && sh_long) sh_len_ok = (r.data_byte == CIDLEN);
    cs = sh_long ? int'(qdss_pkg::LONG_CID_POS) : int'(qdss_pkg::SHORT_CID_POS);
    if (pos > qdss_pkg::FLAGS_POS && pos >= cs && pos < cs + qdss_pkg::KEY_BYTES)
      sh_acc = {sh_acc[55:0], r.data_byte};
    if (sh_pos != 16'hFFFF) sh_pos++;
    if (!r.last_byte) return 0;

    len = pos + 1;
    bad = 0; to_lis = 0; k = '0;
    if (len <= qdss_pkg::FLAGS_POS) bad = 1;
    else if (sh_long && len <= qdss_pkg::LEN_POS) bad = 1;
    else if (sh_long && !sh_len_ok) to_lis = 1;
    else if (len < cs + CIDLEN) bad = 1;
    if (bad) begin
      clear_parse();
      return 1;
    end
    if (!to_lis) begin
      k = sh_acc;
      s = slot_of(k);
      if (s >= 0) begin
        e = mk(1'b1, qdss_pkg::OUT_BY_DCID, sh_socks[s], 1'b0, 10'd0, k);
        clear_parse();
        return 1;
      end
    end
    m = r.flow_hash[31]; tried = 0; tm = 0; w = '0;
    for (int i = 0; i < 2; i++) begin
      cnt = m ? sh_wc1 : sh_wc0;
      if (cnt != 0) begin
        w = 10'(r.flow_hash % {22'd0, cnt});
        tried = 1; tm = m;
        k = listener_key(m, w);
        s = slot_of(k);
        if (s >= 0) begin
          e = mk(1'b1, qdss_pkg::OUT_BY_LIS, sh_socks[s], m, w, k);
          clear_parse();
          return 1;
        end
      end
      m = ~m;
    end
    e = mk(1'b0, qdss_pkg::OUT_NO_LIS, 16'd0, tried ? tm : 1'b0, tried ? w : 10'd0, k);
    clear_parse();
    return 1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_req(steer_req_t r, bit fixed = 0, verdict_t fx = '{default: '0});
    int g;
    verdict_t e;
    g = gap_len();
    if (g > 0) begin
      in_req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.kind         <= r.kind;
    in_req.data_byte    <= r.data_byte;
    in_req.last_byte    <= r.last_byte;
    in_req.flow_hash    <= r.flow_hash;
    in_req.entry_key    <= r.entry_key;
    in_req.entry_socket <= r.entry_socket;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    if (steer_predict(r, e)) pending_verdicts.push_back(fixed ? fx : e);
    if (r.kind != KIND_UNUSED) sent++;
  endtask

  function automatic steer_req_t tbl_req(logic [1:0] kd, logic [63:0] k, logic [15:0] s);
    steer_req_t r;
    r.kind = kd; r.data_byte = 8'($urandom); r.last_byte = 1'($urandom);
    r.flow_hash = $urandom; r.entry_key = k; r.entry_socket = s;
    return r;
  endfunction

  task automatic send_byte(logic [7:0] b, bit last, logic [31:0] h);
    steer_req_t r;
    r = tbl_req(qdss_pkg::KIND_BYTE, {$urandom, $urandom}, 16'($urandom));
    r.data_byte = b; r.last_byte = last; r.flow_hash = h;
    send_req(r);
  endtask

  task automatic wait_idle();
    in_req.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_counts(logic [9:0] c0, logic [9:0] c1);
    wait_idle();
    cfg_we <= 1'b1; cfg_index <= qdss_pkg::REG_WC0; cfg_wdata <= c0;
    @(posedge clk);
    cfg_index <= qdss_pkg::REG_WC1; cfg_wdata <= c1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_wc0 = c0; sh_wc1 = c1;
  endtask

  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return key_pool[$urandom_range(0, 7)];
    if (r < 9) return listener_key(1'($urandom), 10'($urandom_range(0, 7)));
    return {$urandom, $urandom};
  endfunction

  // Builds one datagram; mode 0 short header, 1 long header with a full DCID,
  // 2 long header with a wrong DCID length, 3 random truncated noise.
  task automatic send_dgram(int mode);
    logic [7:0] pkt[$];
    logic [63:0] k;
    logic [31:0] h;
    int cs;
    pkt.delete();
    k = pick_key();
    h = $urandom;
    if (mode == 3) begin
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
    end else begin
      repeat (8) pkt.push_back(8'($urandom));
      pkt.push_back({mode != 0, 7'($urandom)});
      if (mode != 0) begin
        repeat (4) pkt.push_back(8'($urandom));
        pkt.push_back(mode == 1 ? 8'(CIDLEN) : 8'($urandom_range(0, 19)));
      end
      cs = pkt.size();
      for (int i = 0; i < 8; i++) pkt.push_back(k[63 - 8*i -: 8]);
      repeat (CIDLEN - 8) pkt.push_back(8'($urandom));
      // Occasionally cut the DCID short to hit the truncated case.
      if ($urandom_range(0, 9) == 0) pkt = pkt[0 : cs + $urandom_range(0, CIDLEN - 2)];
      else repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom));
    end
    foreach (pkt[i]) begin
      if ($urandom_range(0, 40) == 0)
        send_req(tbl_req($urandom_range(1, 2) == 1 ? qdss_pkg::KIND_INS
                                                   : qdss_pkg::KIND_REM,
                         pick_key(), 16'($urandom)));
      send_byte(pkt[i], i == pkt.size() - 1, h);
    end
  endtask

  task automatic random_phase(int n);
    int r, stop;
    stop = sent + n;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 10) send_req(tbl_req(qdss_pkg::KIND_INS, pick_key(), 16'($urandom)));
      else if (r < 15) send_req(tbl_req(qdss_pkg::KIND_REM, pick_key(), 16'($urandom)));
      else if (r < 17) send_req(tbl_req(KIND_UNUSED, pick_key(), 16'($urandom)));
      else if (r < 18) wait_idle();
      else if (r < 48) send_dgram(0);
      else if (r < 78) send_dgram(1);
      else if (r < 88) send_dgram(2);
      else send_dgram(3);
    end
  endtask

  task automatic add_row(ref dir_row_t rows[$], input steer_req_t r, input bit fixed,
                         input verdict_t fx);
    dir_row_t d;
    d.req = r; d.fixed = fixed; d.res = fx;
    rows.push_back(d);
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result, outcome %0d", out_res.outcome);
        errors++;
      end else begin
        verdict_t e;
        e = pending_verdicts.pop_front();
        if (out_res.verdict !== e.verdict) begin
          $error("verdict: expected %0h, got %0h", e.verdict, out_res.verdict); errors++;
        end
        if (out_res.outcome !== e.outcome) begin
          $error("outcome: expected %0h, got %0h", e.outcome, out_res.outcome); errors++;
        end
        if (out_res.chosen_socket !== e.chosen_socket) begin
          $error("chosen_socket: expected %0h, got %0h", e.chosen_socket,
                 out_res.chosen_socket); errors++;
        end
        if (out_res.chosen_master !== e.chosen_master) begin
          $error("chosen_master: expected %0h, got %0h", e.chosen_master,
                 out_res.chosen_master); errors++;
        end
        if (out_res.chosen_worker !== e.chosen_worker) begin
          $error("chosen_worker: expected %0h, got %0h", e.chosen_worker,
                 out_res.chosen_worker); errors++;
        end
        if (out_res.matched_key !== e.matched_key) begin
          $error("matched_key: expected %0h, got %0h", e.matched_key,
                 out_res.matched_key); errors++;
        end
      end
    end
  end

  // Result-side back-pressure: mostly short stalls, some long ones, and
  // stretches without any.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || no_stall) begin
      out_res.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_res.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_res.ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                : $urandom_range(0, 2);
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  initial begin
    dir_row_t rows[$];
    logic [63:0] filler[$];
    steer_req_t r;
    int n;
    errors = 0; sent = 0; quiet = 0; no_stall = 1;
    rst_n <= 1'b0;
    cfg_we <= 1'b0; cfg_index <= qdss_pkg::REG_WC0; cfg_wdata <= '0;
    in_req.valid <= 1'b0; in_req.kind <= qdss_pkg::KIND_BYTE; in_req.data_byte <= '0;
    in_req.last_byte <= 1'b0; in_req.flow_hash <= '0; in_req.entry_key <= '0;
    in_req.entry_socket <= '0;
    for (int i = 0; i < NSLOTS; i++) begin
      sh_valid[i] = 0; sh_keys[i] = '0; sh_socks[i] = '0;
    end
    clear_parse();
    sh_wc0 = '0; sh_wc1 = '0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: table extremes, error codes, and datagrams too short to parse.
    r = tbl_req(qdss_pkg::KIND_BYTE, 64'd0, 16'd0);
    r.data_byte = 8'hFF; r.last_byte = 1'b1; r.flow_hash = '1;
    add_row(rows, r, 1, mk(1'b0, qdss_pkg::OUT_BAD, 16'd0, 1'b0, 10'd0, 64'd0));
    add_row(rows, tbl_req(qdss_pkg::KIND_REM, '0, 16'd0), 1,
            mk(1'b0, qdss_pkg::OUT_ABSENT, 16'd0, 1'b0, 10'd0, '0));
    add_row(rows, tbl_req(qdss_pkg::KIND_INS, '1, '1), 1,
            mk(1'b0, qdss_pkg::OUT_UPDATED, 16'd0, 1'b0, 10'd0, '1));
    add_row(rows, tbl_req(qdss_pkg::KIND_INS, '1, '0), 1,
            mk(1'b0, qdss_pkg::OUT_UPDATED, 16'd0, 1'b0, 10'd0, '1));
    add_row(rows, tbl_req(qdss_pkg::KIND_REM, '1, 16'd0), 1,
            mk(1'b0, qdss_pkg::OUT_UPDATED, 16'd0, 1'b0, 10'd0, '1));
    add_row(rows, tbl_req(qdss_pkg::KIND_REM, '1, 16'd0), 1,
            mk(1'b0, qdss_pkg::OUT_ABSENT, 16'd0, 1'b0, 10'd0, '1));
    add_row(rows, tbl_req(KIND_UNUSED, '1, '1), 0,
            mk(1'b0, 3'd0, 16'd0, 1'b0, 10'd0, 64'd0));
    add_row(rows, tbl_req(qdss_pkg::KIND_INS, '0, 16'h1234), 0,
            mk(1'b0, 3'd0, 16'd0, 1'b0, 10'd0, 64'd0));
    for (int i = 0; i < 9; i++) begin
      r = tbl_req(qdss_pkg::KIND_BYTE, 64'd0, 16'd0);
      r.data_byte = (i == 8) ? 8'h00 : 8'($urandom); r.last_byte = (i == 8);
      add_row(rows, r, i == 8, mk(1'b0, qdss_pkg::OUT_BAD, 16'd0, 1'b0, 10'd0, 64'd0));
    end
    for (int i = 0; i < 13; i++) begin
      r = tbl_req(qdss_pkg::KIND_BYTE, 64'd0, 16'd0);
      r.data_byte = (i == 8) ? 8'h80 : 8'($urandom); r.last_byte = (i == 12);
      add_row(rows, r, 0, mk(1'b0, 3'd0, 16'd0, 1'b0, 10'd0, 64'd0));
    end
    foreach (rows[i]) send_req(rows[i].req, rows[i].fixed, rows[i].res);

    // One datagram of each mode with no listeners configured, then the count extremes.
    for (int i = 0; i < 4; i++) send_dgram(i);
    set_counts(10'd1, 10'd1);
    send_req(tbl_req(qdss_pkg::KIND_INS, listener_key(1'b0, 10'd0), 16'h00A0));
    send_req(tbl_req(qdss_pkg::KIND_INS, listener_key(1'b1, 10'd0), 16'h00A1));
    no_stall = 0;
    random_phase(40);

    set_counts(10'd1023, 10'd1023);
    random_phase(40);

    // Fill the table until it reports full, then drain it again.
    set_counts(10'd3, 10'd0);
    n = 0;
    while (n < NSLOTS + 3) begin
      r = tbl_req(qdss_pkg::KIND_INS, {$urandom, $urandom}, 16'($urandom));
      filler.push_back(r.entry_key);
      send_req(r);
      n++;
    end
    send_dgram(1);
    foreach (filler[i]) send_req(tbl_req(qdss_pkg::KIND_REM, filler[i], 16'($urandom)));
    for (int w = 0; w < 3; w++)
      send_req(tbl_req(qdss_pkg::KIND_INS, listener_key(1'b0, 10'(w)), 16'($urandom)));
    random_phase(40);

    set_counts(10'd0, 10'd5);
    for (int w = 0; w < 5; w += 2)
      send_req(tbl_req(qdss_pkg::KIND_INS, listener_key(1'b1, 10'(w)), 16'($urandom)));
    // Back-to-back requests with the result side always ready.
    quiet = 1;
    no_stall = 1;
    random_phase(25);
    quiet = 0;
    no_stall = 0;
    random_phase(25);

    set_counts(10'($urandom_range(1, 8)), 10'($urandom_range(1, 8)));
    for (int w = 0; w < 8; w++)
      if ($urandom_range(0, 1))
        send_req(tbl_req(qdss_pkg::KIND_INS, listener_key(1'($urandom), 10'(w)),
                         16'($urandom)));
    random_phase(50);

    set_counts(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    random_phase(20);

    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
